// ===== hw/rtl/ilp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser package
// Word types, parser state type and character and code constants shared by
// the parser step logic and the top level.
// ----------------------------------------------------------------------------
package ilp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [63:0] parsed_value;
    logic        parse_ok;
  } out_word_t;

  localparam logic [2:0] PH_FIRST     = 3'd0;
  localparam logic [2:0] PH_AFTERSIGN = 3'd1;
  localparam logic [2:0] PH_AFTERZERO = 3'd2;
  localparam logic [2:0] PH_DIGITS    = 3'd3;
  localparam logic [2:0] PH_STOPPED   = 3'd4;
  localparam logic [2:0] PH_FAILED    = 3'd5;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  radix;
    logic [63:0] acc;
    logic        minus;
  } parse_state_t;

endpackage

// ===== hw/rtl/ilp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser step
// Next parser state for one character: sign and prefix handling, digit check
// against the radix and the multiply-accumulate done with shifts and adds.
// ----------------------------------------------------------------------------
module ilp_step import ilp_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   char_code,
  input  logic         is_last,
  output parse_state_t nxt,
  output logic         parse_ok
);

  logic [7:0]  lc;
  logic        is_suffix;
  logic        use_lead;
  logic [1:0]  dig_rx;
  logic [63:0] dig_acc;
  logic [3:0]  dval;
  logic        dval_ok;
  logic [63:0] scaled;
  logic [2:0]  dig_phase;
  logic [63:0] dig_acc_next;

  always_comb begin
    if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
      lc = char_code + CASE_GAP;
    end else begin
      lc = char_code;
    end
  end

  assign is_suffix = (lc == CH_LO_L) || (lc == CH_LO_U);
  assign use_lead  = !((cur.phase == PH_AFTERZERO) || (cur.phase == PH_DIGITS));
  assign dig_rx    = use_lead ? RX_DEC : cur.radix;
  assign dig_acc   = use_lead ? 64'd0 : cur.acc;

  always_comb begin
    dval    = 4'd0;
    dval_ok = 1'b0;
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      dval    = 4'(char_code - CH_ZERO);
      dval_ok = 1'b1;
    end else if (lc >= CH_LO_A && lc <= CH_LO_F) begin
      dval    = 4'(lc - CH_LO_A + 8'd10);
      dval_ok = 1'b1;
    end
    case (dig_rx)
      RX_DEC:  if (dval > 4'd9) dval_ok = 1'b0;
      RX_BIN:  if (dval > 4'd1) dval_ok = 1'b0;
      RX_OCT:  if (dval > 4'd7) dval_ok = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    case (dig_rx)
      RX_HEX:  scaled = dig_acc << 4;
      RX_BIN:  scaled = dig_acc << 1;
      RX_OCT:  scaled = dig_acc << 3;
      default: scaled = (dig_acc << 3) + (dig_acc << 1);
    endcase
  end

  always_comb begin
    dig_acc_next = dig_acc;
    if (is_suffix) begin
      dig_phase = PH_STOPPED;
    end else if (!dval_ok) begin
      dig_phase = PH_FAILED;
    end else begin
      dig_phase    = PH_DIGITS;
      dig_acc_next = scaled + {60'd0, dval};
    end
  end

  always_comb begin
    nxt = cur;
    unique case (cur.phase) inside
      PH_AFTERSIGN: begin
        nxt.acc = 64'd0;
        if (char_code == CH_ZERO && !is_last) begin
          nxt.radix = RX_OCT;
          nxt.phase = PH_AFTERZERO;
        end else begin
          nxt.radix = RX_DEC;
          nxt.phase = dig_phase;
          nxt.acc   = dig_acc_next;
        end
      end
      PH_AFTERZERO: begin
        if ((char_code == CH_LO_X || char_code == CH_LO_B) && !is_last) begin
          nxt.radix = (char_code == CH_LO_X) ? RX_HEX : RX_BIN;
          nxt.phase = PH_DIGITS;
        end else begin
          nxt.phase = dig_phase;
          nxt.acc   = dig_acc_next;
        end
      end
      PH_DIGITS: begin
        nxt.phase = dig_phase;
        nxt.acc   = dig_acc_next;
      end
      PH_STOPPED, PH_FAILED: begin
        nxt = cur;
      end
      default: begin
        nxt.minus = 1'b0;
        nxt.acc   = 64'd0;
        nxt.radix = RX_DEC;
        if (char_code == CH_NUL) begin
          nxt.phase = PH_FAILED;
        end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
          nxt.minus = (char_code == CH_MINUS);
          nxt.phase = is_last ? PH_FAILED : PH_AFTERSIGN;
        end else if (char_code == CH_ZERO && !is_last) begin
          nxt.radix = RX_OCT;
          nxt.phase = PH_AFTERZERO;
        end else begin
          nxt.phase = dig_phase;
          nxt.acc   = dig_acc_next;
        end
      end
    endcase
  end

  assign parse_ok = (nxt.phase == PH_DIGITS) || (nxt.phase == PH_STOPPED);

endmodule

// ===== hw/rtl/integer_literal_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser core
// Parses a C-style integer literal fed one character per word and returns
// its 64-bit value and a valid flag.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one character of the literal per word, with
// is_last set on its final character. The output channel carries one word
// per literal, produced by its last character: the value modulo 2^64 (two's
// complement negated after a minus sign) and parse_ok. When parse_ok is low
// the value reads as zero.
// The block is a pipeline of an input register, the parse state with a
// result register, and an output register. A result passes from the input
// register through the result register to the output register. One character
// is taken per cycle unless the input stalls as described below.
// A synchronous reset empties the pipeline and returns the parser to the
// start of a literal. While the receiver stalls, the pending result and one
// more finished result are held, and characters that end no literal keep
// flowing into the parse state; input stalls only when a last character
// finds no free result register.
// ----------------------------------------------------------------------------
module integer_literal_parser_core import ilp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic         a_valid;
  in_word_t     a_word;
  logic         b_valid;
  logic [63:0]  b_acc;
  logic         b_minus;
  logic         b_ok;
  parse_state_t state;
  parse_state_t state_next;
  logic         step_ok;
  logic         o_free;
  logic         b_free;
  logic         a_move;

  ilp_step u_step (
    .cur       (state),
    .char_code (a_word.char_code),
    .is_last   (a_word.is_last),
    .nxt       (state_next),
    .parse_ok  (step_ok)
  );

  assign o_free   = !out_valid || out_ready;
  assign b_free   = !b_valid || o_free;
  assign a_move   = a_valid && (!a_word.is_last || b_free);
  assign in_ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_FIRST, radix: RX_DEC, acc: 64'd0, minus: 1'b0};
    end else if (a_move) begin
      if (a_word.is_last) begin
        state <= '{phase: PH_FIRST, radix: RX_DEC, acc: 64'd0, minus: 1'b0};
      end else begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_move && a_word.is_last;
    end
    if (a_move && a_word.is_last) begin
      b_acc   <= state_next.acc;
      b_minus <= state_next.minus;
      b_ok    <= step_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= b_valid;
    end
    if (b_valid && o_free) begin
      out_word.parse_ok <= b_ok;
      if (!b_ok) begin
        out_word.parsed_value <= 64'd0;
      end else if (b_minus) begin
        out_word.parsed_value <= 64'd0 - b_acc;
      end else begin
        out_word.parsed_value <= b_acc;
      end
    end
  end

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.parse_ok |-> out_word.parsed_value == 64'd0)
    else $error("Failed literal reports a nonzero value.");

  a_state_restart: assert property (@(posedge clk) disable iff (rst)
    a_move && a_word.is_last |=> state.phase == PH_FIRST && state.acc == 64'd0
      && !state.minus)
    else $error("Parser state not restarted after a last character.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    b_valid && !o_free |=> b_valid)
    else $error("Pending result dropped while the output stalls.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> in_ready)
    else $error("Input not ready with an empty input register.");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser testbench
// Feeds C-style integer literals to the parser one character per word, with
// directed corner cases, random literals under several idle and stall mixes,
// a long output stall and a full drain pause. Each result word is checked
// field by field against a cycle-free software parser kept in step with the
// accepted characters.
// ----------------------------------------------------------------------------
module tb_top;
  import ilp_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 10;
  localparam logic [7:0]  NO_DIGIT    = 8'hff;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  integer_literal_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  logic [2:0]  lit_phase;
  logic [1:0]  lit_radix;
  logic [63:0] lit_acc;
  logic        lit_minus;

  out_word_t expected_words[$];
  int        error_count = 0;
  int        chars_sent = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] radix_base(input logic [1:0] rx);
    case (rx)
      RX_HEX:  return 64'd16;
      RX_BIN:  return 64'd2;
      RX_OCT:  return 64'd8;
      default: return 64'd10;
    endcase
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_value(input logic [7:0] c, input logic [1:0] rx);
    logic [7:0] lc;
    logic [7:0] d;
    lc = fold_case(c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (lc >= CH_LO_A && lc <= CH_LO_F) begin
      d = lc - CH_LO_A + 8'd10;
    end else begin
      return NO_DIGIT;
    end
    return (64'(d) < radix_base(rx)) ? d : NO_DIGIT;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = fold_case(c);
    if (lc == CH_LO_L || lc == CH_LO_U) begin
      lit_phase = PH_STOPPED;
      return;
    end
    d = digit_value(c, lit_radix);
    if (d == NO_DIGIT) begin
      lit_phase = PH_FAILED;
      return;
    end
    lit_acc = lit_acc * radix_base(lit_radix) + 64'(d);
    lit_phase = PH_DIGITS;
  endfunction

  function automatic void take_lead(input logic [7:0] c, input logic last);
    lit_acc = '0;
    if (c == CH_ZERO && !last) begin
      lit_radix = RX_OCT;
      lit_phase = PH_AFTERZERO;
    end else begin
      lit_radix = RX_DEC;
      take_digit(c);
    end
  endfunction

  function automatic void clear_literal();
    lit_phase = PH_FIRST;
    lit_radix = RX_DEC;
    lit_acc   = '0;
    lit_minus = 1'b0;
  endfunction

  function automatic logic parse_char(input in_word_t w, output out_word_t res);
    logic [7:0] c;
    logic       ok;
    c = w.char_code;
    res = '0;
    case (lit_phase) inside
      PH_AFTERSIGN: take_lead(c, w.is_last);
      PH_AFTERZERO: begin
        if ((c == CH_LO_X || c == CH_LO_B) && !w.is_last) begin
          lit_radix = (c == CH_LO_X) ? RX_HEX : RX_BIN;
          lit_phase = PH_DIGITS;
        end else begin
          take_digit(c);
        end
      end
      PH_DIGITS: take_digit(c);
      PH_STOPPED, PH_FAILED: ;
      default: begin
        lit_minus = 1'b0;
        lit_acc   = '0;
        lit_radix = RX_DEC;
        if (c == CH_NUL) begin
          lit_phase = PH_FAILED;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          lit_minus = (c == CH_MINUS);
          lit_phase = w.is_last ? PH_FAILED : PH_AFTERSIGN;
        end else begin
          take_lead(c, w.is_last);
        end
      end
    endcase
    if (!w.is_last) begin
      return 1'b0;
    end
    ok = (lit_phase == PH_DIGITS || lit_phase == PH_STOPPED);
    res.parse_ok = ok;
    res.parsed_value = ok ? (lit_minus ? -lit_acc : lit_acc) : 64'd0;
    clear_literal();
    return 1'b1;
  endfunction

  // Inputs change only at rising edges, so both handshakes are sampled at the
  // falling edge that precedes the accepting rising edge.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(negedge clk) begin
    out_word_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h ok=%b",
                                  out_word.parsed_value, out_word.parse_ok));
      end else begin
        exp_word = expected_words.pop_front();
        if (out_word.parse_ok !== exp_word.parse_ok) begin
          report_mismatch($sformatf("parse_ok got %b want %b",
                                    out_word.parse_ok, exp_word.parse_ok));
        end
        if (out_word.parsed_value !== exp_word.parsed_value) begin
          report_mismatch($sformatf("parsed_value got %h want %h",
                                    out_word.parsed_value, exp_word.parsed_value));
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    in_word_t  w;
    out_word_t res;
    w.char_code = c;
    w.is_last = last;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
    end while (!in_ready);
    if (parse_char(w, res)) begin
      expected_words.push_back(res);
    end
    chars_sent++;
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] random_digit(input logic [1:0] rx);
    int d;
    d = $urandom_range(0, int'(radix_base(rx)) - 1);
    if (d < 10) begin
      return CH_ZERO + 8'(d);
    end
    return (CH_LO_A + 8'(d - 10)) - ($urandom_range(0, 1) ? CASE_GAP : 8'd0);
  endfunction

  task automatic send_random_literal();
    logic [7:0] text[$];
    logic [1:0] rx;
    int         ndig;
    bit         all_f;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: text.push_back(CH_PLUS);
        1: text.push_back(CH_MINUS);
        default: ;
      endcase
      rx = 2'($urandom_range(0, 3));
      all_f = 1'b0;
      case (rx)
        RX_HEX: begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(0, 9) == 0 ? CH_LO_X - CASE_GAP : CH_LO_X);
          all_f = ($urandom_range(0, 9) == 0);
        end
        RX_BIN: begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(0, 9) == 0 ? CH_LO_B - CASE_GAP : CH_LO_B);
        end
        RX_OCT: text.push_back(CH_ZERO);
        default: ;
      endcase
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
      if (all_f) begin
        ndig = 16;
      end
      repeat (ndig) text.push_back(all_f ? CH_LO_F : random_digit(rx));
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: text.push_back(CH_LO_L);
          1: text.push_back(CH_LO_L - CASE_GAP);
          2: text.push_back(CH_LO_U);
          default: text.push_back(CH_LO_U - CASE_GAP);
        endcase
        repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  task automatic test_corner_literals();
    idle_pct = 0;
    stall_pct = 0;
    send_char(CH_NUL, 1'b1);
    send_text("-");
    send_text("0");
    send_text("0x");
    send_text("0X1");
    send_text("-0xfF");
    send_text("0b1");
    send_text("U");
    send_char("1", 1'b0);
    send_char("L", 1'b0);
    send_char(8'hff, 1'b1);
    send_char("9", 1'b0);
    send_char(8'h80, 1'b1);
    send_text("08");
  endtask

  task automatic test_random_literals(input int idle, input int stall, input int n);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = chars_sent + n;
    while (chars_sent < stop_at) begin
      send_random_literal();
    end
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 80;
    for (int i = 0; i < 40; i++) begin
      send_char(CH_ZERO + 8'(i % 10), 1'b1);
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 20;
    stall_pct = 20;
    repeat (6) send_random_literal();
    wait_drained();
    repeat (6) send_random_literal();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    clear_literal();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_literals();
    test_random_literals(0, 0, 90);
    test_random_literals(53, 0, 90);
    test_random_literals(0, 53, 90);
    test_random_literals(6, 6, 90);
    test_output_hold();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_step.sv
hw/rtl/integer_literal_parser_core.sv
tb/tb_top.sv
